>>> src/pngu_pkg.sv
// shared types and constants for the png scanline unfilter block
`default_nettype none

package pngu_pkg;

	localparam int BYTES_PER_PIXEL = 3;

	localparam logic [2:0] FILT_NONE  = 3'd0;
	localparam logic [2:0] FILT_SUB   = 3'd1;
	localparam logic [2:0] FILT_UP    = 3'd2;
	localparam logic [2:0] FILT_AVG   = 3'd3;
	localparam logic [2:0] FILT_PAETH = 3'd4;

	localparam logic [7:0] BYTE_MASK = 8'hff;

	localparam logic CFG_IMAGE_WIDTH  = 1'b0;
	localparam logic CFG_IMAGE_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0]  data;
		logic [1:0]  channel;
		logic [9:0]  column;
		logic [15:0] row;
		logic [2:0]  filter;
		logic        bad;
		logic        first_col;
		logic        last_of_row;
		logic        last_of_image;
	} pngu_task_t;

endpackage

`default_nettype wire

>>> src/pngu_in_if.sv
// input channel: one filtered stream byte per item
`default_nettype none

interface pngu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] stream_byte;

	modport source (output valid, output stream_byte, input ready);
	modport sink (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

>>> src/pngu_out_if.sv
// output channel: one reconstructed byte with position marks per item
`default_nettype none

interface pngu_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  recon_byte;
	logic [1:0]  channel;
	logic [9:0]  column;
	logic [15:0] row;
	logic        last_of_row;
	logic        last_of_image;
	logic        unknown_filter;

	modport source (
		output valid, output recon_byte, output channel, output column, output row,
		output last_of_row, output last_of_image, output unknown_filter, input ready
	);
	modport sink (
		input valid, input recon_byte, input channel, input column, input row,
		input last_of_row, input last_of_image, input unknown_filter, output ready
	);
endinterface

`default_nettype wire

>>> src/pngu_ram.sv
// generic single write port ram with registered read
`default_nettype none

module pngu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 3072
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> src/pngu_front.sv
// front end: takes stream bytes, decodes row filters, tracks position and row
`default_nettype none

module pngu_front import pngu_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic [10:0]                              image_width,
	input  wire logic [15:0]                              image_height,
	pngu_in_if.sink                                       in_ch,
	input  wire logic                                     queue_full,
	output logic                                          push,
	output pngu_task_t                                    task_d,
	output logic [$clog2(MAX_WIDTH*BYTES_PER_PIXEL)-1:0]  pos_d
);

	localparam int LINE_DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;
	localparam int AW = $clog2(LINE_DEPTH);
	localparam int RBW = $clog2(LINE_DEPTH + 1);

	logic          awaiting_q;
	logic [AW-1:0] pos_q;
	logic [1:0]    ch_q;
	logic [9:0]    col_q;
	logic [15:0]   row_q;
	logic [2:0]    filter_q;
	logic          bad_q;

	logic [10:0]    w0;
	logic [15:0]    h0;
	logic [RBW-1:0] row_bytes;
	logic           end_row;
	logic           end_image;
	logic           accept;

	always_comb begin
		w0 = (image_width == '0) ? 11'd1 : image_width;
		h0 = (image_height == '0) ? 16'd1 : image_height;
		if (32'(w0) > 32'(MAX_WIDTH)) begin
			row_bytes = RBW'(LINE_DEPTH);
		end else begin
			row_bytes = RBW'(32'(w0) * 32'(BYTES_PER_PIXEL));
		end
		end_row   = ((RBW+1)'(pos_q) + (RBW+1)'(1)) >= (RBW+1)'(row_bytes);
		end_image = end_row && ((17'(row_q) + 17'd1) >= 17'(h0));
	end

	assign in_ch.ready = awaiting_q | ~queue_full;
	assign accept      = in_ch.valid & in_ch.ready;
	assign push        = accept & ~awaiting_q;

	always_comb begin
		task_d.data          = in_ch.stream_byte;
		task_d.channel       = ch_q;
		task_d.column        = col_q;
		task_d.row           = row_q;
		task_d.filter        = filter_q;
		task_d.bad           = bad_q;
		task_d.first_col     = (pos_q < AW'(BYTES_PER_PIXEL));
		task_d.last_of_row   = end_row;
		task_d.last_of_image = end_image;
		pos_d                = pos_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			pos_q      <= '0;
			ch_q       <= '0;
			col_q      <= '0;
			row_q      <= '0;
			filter_q   <= FILT_NONE;
			bad_q      <= 1'b0;
		end else if (accept) begin
			if (awaiting_q) begin
				if (in_ch.stream_byte > 8'(FILT_PAETH)) begin
					filter_q <= FILT_NONE;
					bad_q    <= 1'b1;
				end else begin
					filter_q <= in_ch.stream_byte[2:0];
					bad_q    <= 1'b0;
				end
				pos_q      <= '0;
				ch_q       <= '0;
				col_q      <= '0;
				awaiting_q <= 1'b0;
			end else if (end_row) begin
				awaiting_q <= 1'b1;
				pos_q      <= '0;
				ch_q       <= '0;
				col_q      <= '0;
				row_q      <= end_image ? 16'd0 : row_q + 16'd1;
			end else begin
				pos_q <= pos_q + AW'(1);
				if (ch_q == 2'(BYTES_PER_PIXEL - 1)) begin
					ch_q  <= '0;
					col_q <= col_q + 10'd1;
				end else begin
					ch_q <= ch_q + 2'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> src/pngu_queue.sv
// small fifo between front and back end
`default_nettype none

module pngu_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  not_empty,
	output logic                  full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [PW:0]      count_q;

	assign rdata     = slot_q[rd_q];
	assign not_empty = (count_q != '0);
	assign full      = (count_q == (PW+1)'(DEPTH));

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (PW+1)'(1);
				2'b01:   count_q <= count_q - (PW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> src/pngu_back.sv
// back end: line store read, filter reconstruction, line store write, output register
`default_nettype none

module pngu_back import pngu_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire logic                                    q_valid,
	input  wire pngu_task_t                              q_task,
	input  wire logic [$clog2(MAX_WIDTH*BYTES_PER_PIXEL)-1:0] q_pos,
	output logic                                         pop,
	pngu_out_if.source                                   out_ch
);

	localparam int LINE_DEPTH = MAX_WIDTH * BYTES_PER_PIXEL;
	localparam int AW = $clog2(LINE_DEPTH);

	logic          valid_s1;
	pngu_task_t    task_s1;
	logic [AW-1:0] pos_s1;
	logic [7:0]    above_s1;

	logic [7:0] left_q  [BYTES_PER_PIXEL];
	logic [7:0] uleft_q [BYTES_PER_PIXEL];

	logic              out_valid_q;
	logic              advance;
	logic [7:0]        a, b, c, pred, recon;
	logic [8:0]        avg_sum;
	logic signed [10:0] pa, pb, pc;

	assign advance = valid_s1 & (~out_valid_q | out_ch.ready);
	assign pop     = q_valid & (~valid_s1 | advance);

	pngu_ram #(
		.WIDTH(8),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk    (clk),
		.we     (advance),
		.waddr  (pos_s1),
		.wdata  (recon),
		.re     (pop),
		.raddr  (q_pos),
		.rdata_q(above_s1)
	);

	always_comb begin
		b = (task_s1.row == '0) ? 8'd0 : above_s1;
		if (task_s1.first_col) begin
			a = 8'd0;
			c = 8'd0;
		end else begin
			a = left_q[task_s1.channel];
			c = (task_s1.row == '0) ? 8'd0 : uleft_q[task_s1.channel];
		end
		avg_sum = 9'(a) + 9'(b);
		pa = 11'(b) - 11'(c);
		pb = 11'(a) - 11'(c);
		pc = 11'(a) + 11'(b) - 11'(c) - 11'(c);
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		unique case (task_s1.filter)
			FILT_SUB:   pred = a;
			FILT_UP:    pred = b;
			FILT_AVG:   pred = avg_sum[8:1];
			FILT_PAETH: begin
				if (pa <= pb && pa <= pc) pred = a;
				else if (pb <= pc)        pred = b;
				else                      pred = c;
			end
			default:    pred = 8'd0;
		endcase
		recon = (task_s1.data + pred) & BYTE_MASK;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			task_s1 <= q_task;
			pos_s1  <= q_pos;
		end
		if (advance) begin
			left_q[task_s1.channel]  <= recon;
			uleft_q[task_s1.channel] <= b;
			out_ch.recon_byte        <= recon;
			out_ch.channel           <= task_s1.channel;
			out_ch.column            <= task_s1.column;
			out_ch.row               <= task_s1.row;
			out_ch.last_of_row       <= task_s1.last_of_row;
			out_ch.last_of_image     <= task_s1.last_of_image;
			out_ch.unknown_filter    <= task_s1.bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid = out_valid_q;

endmodule

`default_nettype wire

>>> src/png_scanline_unfilter_rgb8_core.sv
// top level of the png rgb8 scanline unfilter
//
// channel  | dir | handshake     | payload
// in_ch    | in  | valid / ready | stream_byte
// out_ch   | out | valid / ready | recon_byte channel column row last_of_row last_of_image
//          |     |               | unknown_filter
// cfg      | in  | cfg_we        | cfg_index cfg_wdata
//
// one item per cycle sustained while out_ch is ready; a pixel byte passes through the queue,
// the line store read stage and the output register on its way to the result
// filter bytes are taken but give no result
// reset clears counters and valid flags; the line store needs no clearing pass
// a stall on out_ch fills the two-entry queue, then in_ch.ready drops for pixel bytes
`default_nettype none

module png_scanline_unfilter_rgb8_core import pngu_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	pngu_in_if.sink          in_ch,
	pngu_out_if.source       out_ch
);

	localparam int AW = $clog2(MAX_WIDTH * BYTES_PER_PIXEL);
	localparam int QW = $bits(pngu_task_t) + AW;

	logic [10:0] image_width_q;
	logic [15:0] image_height_q;

	logic          push, pop, q_full, q_valid;
	pngu_task_t    task_d, q_task;
	logic [AW-1:0] pos_d, q_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd1;
			image_height_q <= 16'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[10:0];
				CFG_IMAGE_HEIGHT: image_height_q <= cfg_wdata;
				default:          image_width_q  <= image_width_q;
			endcase
		end
	end

	pngu_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.in_ch       (in_ch),
		.queue_full  (q_full),
		.push        (push),
		.task_d      (task_d),
		.pos_d       (pos_d)
	);

	pngu_queue #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    ({task_d, pos_d}),
		.pop      (pop),
		.rdata    ({q_task, q_pos}),
		.not_empty(q_valid),
		.full     (q_full)
	);

	pngu_back #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_valid(q_valid),
		.q_task (q_task),
		.q_pos  (q_pos),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire
